[sv/crl_pkg.sv]
// Shared types and codes for the channel rate limiter.
// Holds the channel table entry layout, command, status and mode codes.
// No dependencies; imported by channel_rate_limiter.
package crl_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int KEY_W      = 16;
    localparam int TIME_W     = 63;
    localparam int SIZE_W     = 24;
    localparam int MODE_W     = 2;
    localparam int INTERVAL_W = 32;
    localparam int INDEX_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 32;
    localparam int BYTES_W    = 40;

    // Stream widths (payload padded to whole bytes)
    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = STATUS_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // Entry modes; codes with the upper bit set are rate limited
    localparam logic [MODE_W-1:0] MODE_ALWAYS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEMAND = 2'd1;

    // One channel table entry
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [MODE_W-1:0]     mode;
        logic [INTERVAL_W-1:0] interval;
        logic                  dir;
        logic [TIME_W-1:0]     last;
        logic [COUNT_W-1:0]    count;
        logic [BYTES_W-1:0]    bytes;
    } crl_entry_t;

    localparam int ENTRY_W = $bits(crl_entry_t);

    // One result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                send;
        logic                dir;
        logic                demand;
        logic [COUNT_W-1:0]  count;
        logic [BYTES_W-1:0]  bytes;
    } crl_result_t;

endpackage

[sv/crl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the channel table; no dependencies.
module crl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/channel_rate_limiter.sv]
// Channel rate limiter: keeps a table of up to TABLE_ENTRIES channel entries in one
// synchronous RAM and answers one beat per input beat. For a message check, the table
// is scanned in insertion order at one RAM read per cycle until the first key match,
// followed by a read-modify-write of the matched entry. The block takes a new beat
// once the previous one is finished, even while its result still waits in the output
// register. No clearing pass runs after reset; entries above the fill count are never
// read. Depends on crl_pkg and crl_ram.
module channel_rate_limiter #(
    parameter int TABLE_ENTRIES = crl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata: channel_key, msg_time_us, msg_size, entry_mode, min_interval_us,
    //        toward_base, entry_index (lowest bit up), zero pad to 144
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [crl_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: cmd
    input  logic [crl_pkg::S_TUSER_W-1:0]    s_tuser,
    // tdata: send, direction_out, demand flag, sent_count, sent_bytes (lowest bit up),
    //        zero pad to 80
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [crl_pkg::M_TDATA_W-1:0]    m_tdata,
    // tuser: status
    output logic [crl_pkg::M_TUSER_W-1:0]    m_tuser
);

    import crl_pkg::*;

    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ADD   = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_UPD   = 7'b0001000,
        S_RDREQ = 7'b0010000,
        S_RDRSP = 7'b0100000,
        S_MISS  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Held input beat
    logic [KEY_W-1:0]      key_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [INTERVAL_W-1:0] ival_reg;
    logic                  dir_reg;
    logic [INDEX_W-1:0]    idx_reg;

    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic             pend_reg, pend_next;

    logic             m_tvalid_reg;
    crl_result_t      res_reg, res_next;
    logic             out_load;
    logic             out_free;

    // RAM ports
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    crl_entry_t       ram_wdata, ram_rdata;

    // Entry update terms
    logic                  hit;
    logic                  full;
    logic                  idx_ok;
    logic                  issue_now;
    logic [CNT_W+INDEX_W-1:0] idx_ext;
    logic [CNT_W-1:0]      upd_addr;
    logic [TIME_W:0]       elapsed;
    logic                  elapsed_ok;
    logic                  do_send;
    logic [BYTES_W:0]      bytes_sum;
    crl_entry_t            upd_entry;

    logic s_accept;

    crl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Table lookups
    assign hit       = (ram_rdata.key == key_reg);
    assign full      = (used_reg == CNT_W'(TABLE_ENTRIES));
    assign idx_ext   = {{CNT_W{1'b0}}, idx_reg};
    assign idx_ok    = (idx_ext < {{INDEX_W{1'b0}}, used_reg});
    assign issue_now = (state_reg == S_SCAN) && (scan_addr_reg < used_reg)
                       && !(pend_reg && hit);
    assign upd_addr  = scan_addr_reg - CNT_W'(1);

    // Send decision and counter update for the matched entry
    assign elapsed    = {1'b0, time_reg} - {1'b0, ram_rdata.last};
    assign elapsed_ok = !elapsed[TIME_W]
                        && (elapsed[TIME_W-1:0] > {{(TIME_W-INTERVAL_W){1'b0}},
                                                   ram_rdata.interval});
    assign do_send    = !ram_rdata.mode[1] || elapsed_ok;
    assign bytes_sum  = {1'b0, ram_rdata.bytes} + {{(BYTES_W+1-SIZE_W){1'b0}}, size_reg};

    always_comb begin
        upd_entry = ram_rdata;
        if (do_send) begin
            if (ram_rdata.mode[1]) begin
                upd_entry.last = time_reg;
            end
            if (ram_rdata.count != {COUNT_W{1'b1}}) begin
                upd_entry.count = ram_rdata.count + COUNT_W'(1);
            end
            upd_entry.bytes = bytes_sum[BYTES_W] ? {BYTES_W{1'b1}}
                                                 : bytes_sum[BYTES_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = used_reg[AW-1:0];
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = scan_addr_reg[AW-1:0];
        out_load       = 1'b0;
        res_next       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    scan_addr_next = '0;
                    unique case (s_tuser)
                        CMD_ADD:   state_next = S_ADD;
                        CMD_CHECK: state_next = S_SCAN;
                        CMD_READ:  state_next = S_RDREQ;
                        default:   state_next = S_MISS;
                    endcase
                end
            end
            S_ADD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (full) begin
                        res_next.status = ST_FULL;
                    end else begin
                        ram_we             = 1'b1;
                        ram_wdata.key      = key_reg;
                        ram_wdata.mode     = mode_reg;
                        ram_wdata.interval = ival_reg;
                        ram_wdata.dir      = dir_reg;
                        used_next          = used_reg + CNT_W'(1);
                    end
                end
            end
            S_SCAN: begin
                // issue one read a cycle, compare the previous one
                ram_re    = issue_now;
                pend_next = issue_now;
                if (issue_now) begin
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                if (pend_reg && hit) begin
                    state_next = S_UPD;
                end else if (!issue_now) begin
                    state_next = S_MISS;
                end
            end
            S_UPD: begin
                if (out_free) begin
                    ram_we             = 1'b1;
                    ram_waddr          = upd_addr[AW-1:0];
                    ram_wdata          = upd_entry;
                    out_load           = 1'b1;
                    res_next.status    = ST_OK;
                    res_next.send      = do_send;
                    res_next.dir       = upd_entry.dir;
                    res_next.demand    = (upd_entry.mode == MODE_DEMAND);
                    res_next.count     = upd_entry.count;
                    res_next.bytes     = upd_entry.bytes;
                    state_next         = S_IDLE;
                end
            end
            S_RDREQ: begin
                if (idx_ok) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_ext[AW-1:0];
                    state_next = S_RDRSP;
                end else begin
                    state_next = S_MISS;
                end
            end
            S_RDRSP: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    res_next.status    = ST_OK;
                    res_next.dir       = ram_rdata.dir;
                    res_next.demand    = (ram_rdata.mode == MODE_DEMAND);
                    res_next.count     = ram_rdata.count;
                    res_next.bytes     = ram_rdata.bytes;
                    state_next         = S_IDLE;
                end
            end
            S_MISS: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    res_next.status = ST_MISS;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            scan_addr_reg <= scan_addr_next;
            pend_reg      <= pend_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg  <= s_tdata[15:0];
            time_reg <= s_tdata[78:16];
            size_reg <= s_tdata[102:79];
            mode_reg <= s_tdata[104:103];
            ival_reg <= s_tdata[136:105];
            dir_reg  <= s_tdata[137];
            idx_reg  <= s_tdata[141:138];
        end
    end

    // Hold the result beat
    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {5'b0, res_reg.bytes, res_reg.count, res_reg.demand,
                       res_reg.dir, res_reg.send};

    // Fill count never passes the table depth
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table depth");

    // Scan never runs past the fill count
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (scan_addr_reg <= used_reg))
        else $error("scan address beyond fill count");

    // A key match during the scan leads to the update state
    a_hit_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && pend_reg && hit) |=> (state_reg == S_UPD))
        else $error("matched entry not updated");

    // Table writes only come from an add or an entry update with a free output
    a_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == S_ADD || state_reg == S_UPD) && out_free))
        else $error("unexpected table write");

    // Loading a result always returns the block to idle
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == S_IDLE && m_tvalid_reg))
        else $error("result load without return to idle");

endmodule
